### design/pcp_pkg.sv
// Shared types and constants for the pedal control panel.
`timescale 1ns / 1ps

package pcp_pkg;

    // Field widths fixed by the panel item and result formats
    localparam int GAIN_W   = 16;
    localparam int OFFSET_W = 16;
    localparam int ZONE_W   = 15;
    localparam int POS_W    = 17;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_TDATA_W = 32;

    // Parameter defaults
    localparam int NUM_SLOTS_DEF = 4;
    localparam int KNOB_BITS_DEF = 12;

    // Register reset values
    localparam logic [GAIN_W-1:0]   KNOB_GAIN_RST   = 16'd16876;
    localparam logic [OFFSET_W-1:0] KNOB_OFFSET_RST = 16'd983;
    localparam logic [ZONE_W-1:0]   DEADBAND_RST    = 15'd983;

    localparam logic [POS_W-1:0] Q16_ONE = 17'h10000;

    // Switch modes
    localparam logic [1:0] MODE_SET       = 2'b00;
    localparam logic [1:0] MODE_MOMENTARY = 2'b01;
    localparam logic [1:0] MODE_LATCH     = 2'b10;
    localparam logic [1:0] MODE_BOTH      = 2'b11;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KNOB_GAIN   = 2'd0,
        REG_KNOB_OFFSET = 2'd1,
        REG_DEADBAND    = 2'd2
    } pcp_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   knob_gain;
        logic [OFFSET_W-1:0] knob_offset;
        logic [ZONE_W-1:0]   deadband;
    } pcp_cfg_t;

    // Captured item, knob already scaled to Q16
    typedef struct packed {
        logic             toggle_a_low;
        logic             toggle_b_low;
        logic             foot_level;
        logic [POS_W-1:0] knob_pos;
    } pcp_item_t;

    typedef struct packed {
        logic [POS_W-1:0] knob_position;
        logic             knob_accepted;
        logic             param_changed;
        logic             slot_changed;
        logic [2:0]       routed_slot;
        logic [1:0]       effect_slot;
        logic [1:0]       switch_mode;
        logic             fx_on;
    } pcp_result_t;

endpackage

### design/pcp_knob_scale.sv
// Knob code scaling to Q16: (code * gain >> 10) - offset, clamped to 0..1.0.
`timescale 1ns / 1ps

module pcp_knob_scale import pcp_pkg::*; #(
    parameter int KNOB_BITS = KNOB_BITS_DEF
) (
    input  logic [KNOB_BITS-1:0] knob_code,
    input  logic [GAIN_W-1:0]    knob_gain,
    input  logic [OFFSET_W-1:0]  knob_offset,
    output logic [POS_W-1:0]     knob_pos
);

    localparam int PROD_W = KNOB_BITS + GAIN_W;
    localparam int SUM_W  = KNOB_BITS + GAIN_W + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  scaled;
    logic [SUM_W-1:0]  offset_ext;
    logic [SUM_W-1:0]  diff;

    always_comb begin
        prod       = PROD_W'(knob_code) * PROD_W'(knob_gain);
        scaled     = SUM_W'(prod >> 10);
        offset_ext = SUM_W'(knob_offset);
        diff       = scaled - offset_ext;
        if (scaled <= offset_ext) begin
            knob_pos = '0;
        end else if (diff > SUM_W'(Q16_ONE)) begin
            knob_pos = Q16_ONE;
        end else begin
            knob_pos = diff[POS_W-1:0];
        end
    end

endmodule

### design/pcp_panel_core.sv
// Panel state: mode, enable, slot and knob tracking; result for the item in flight.
`timescale 1ns / 1ps

module pcp_panel_core import pcp_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  pcp_item_t   item,
    input  pcp_cfg_t    cfg,
    output pcp_result_t result
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int SPROD_W = POS_W + SLOT_W + 1;
    localparam logic [SLOT_W:0]   SLOT_PASS = (SLOT_W+1)'(NUM_SLOTS);
    localparam logic [SLOT_W+1:0] SLOT_LIM  = (SLOT_W+2)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(NUM_SLOTS - 1);

    logic [1:0]        mode_reg, mode_next;
    logic              enable_reg, enable_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              foot_last_reg, foot_last_next;
    logic              wide_zone_reg, wide_zone_next;
    logic [POS_W-1:0]  knob_last_reg, knob_last_next;
    logic              have_reading_reg, have_reading_next;

    logic [1:0]          mode;
    logic                en_mode;
    logic                wide_mode;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    zone;
    logic [POS_W-1:0]    diff;
    logic                accept;
    logic [SPROD_W-1:0]  slot_prod;
    logic [SLOT_W+1:0]   slot_raw;
    logic [SLOT_W-1:0]   slot_pick;
    logic [SLOT_W:0]     routed_wide;
    logic [SLOT_W+2:0]   slot_ext;
    logic [SLOT_W+3:0]   routed_ext;

    always_comb begin
        mode = {~item.toggle_b_low, ~item.toggle_a_low};
        pos  = item.knob_pos;

        // mode change drops the enable and widens the dead zone
        en_mode   = (mode != mode_reg) ? 1'b0 : enable_reg;
        wide_mode = (mode != mode_reg) | wide_zone_reg;

        enable_next    = en_mode;
        foot_last_next = item.foot_level;
        if (item.foot_level != foot_last_reg) begin
            if (mode == MODE_LATCH && item.foot_level) begin
                enable_next = ~en_mode;
            end else if (mode == MODE_MOMENTARY) begin
                enable_next = item.foot_level;
            end
        end

        zone = wide_mode ? {cfg.deadband, 2'b00} : POS_W'(cfg.deadband);
        diff = (pos >= knob_last_reg) ? pos - knob_last_reg : knob_last_reg - pos;
        accept = !have_reading_reg
              || (pos == Q16_ONE && knob_last_reg != Q16_ONE)
              || (pos == '0 && knob_last_reg != '0)
              || (diff >= zone);

        slot_prod = SPROD_W'(pos) * SPROD_W'(NUM_SLOTS);
        slot_raw  = slot_prod[SPROD_W-1:16];
        slot_pick = (slot_raw >= SLOT_LIM) ? SLOT_TOP : slot_raw[SLOT_W-1:0];

        mode_next         = mode;
        wide_zone_next    = wide_mode;
        knob_last_next    = knob_last_reg;
        have_reading_next = have_reading_reg;
        slot_next         = slot_reg;
        result            = '0;
        if (accept) begin
            wide_zone_next    = 1'b0;
            knob_last_next    = pos;
            have_reading_next = 1'b1;
            if (mode != MODE_SET) begin
                result.param_changed = 1'b1;
            end else begin
                result.slot_changed = (slot_pick != slot_reg);
                slot_next           = slot_pick;
            end
        end

        routed_wide = enable_next ? {1'b0, slot_next} : SLOT_PASS;
        slot_ext    = {3'b000, slot_next};
        routed_ext  = {3'b000, routed_wide};

        result.fx_on         = enable_next;
        result.switch_mode   = mode;
        result.effect_slot   = slot_ext[1:0];
        result.routed_slot   = routed_ext[2:0];
        result.knob_accepted = accept;
        result.knob_position = accept ? pos : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_SET;
            enable_reg       <= 1'b1;
            slot_reg         <= '0;
            foot_last_reg    <= 1'b0;
            wide_zone_reg    <= 1'b0;
            knob_last_reg    <= '0;
            have_reading_reg <= 1'b0;
        end else if (step) begin
            mode_reg         <= mode_next;
            enable_reg       <= enable_next;
            slot_reg         <= slot_next;
            foot_last_reg    <= foot_last_next;
            wide_zone_reg    <= wide_zone_next;
            knob_last_reg    <= knob_last_next;
            have_reading_reg <= have_reading_next;
        end
    end

    // a reading drives either a slot pick or a parameter change, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !(result.slot_changed && result.param_changed))
        else $error("slot and parameter change in one item");

    // once a reading is taken it stays taken until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        have_reading_reg |=> have_reading_reg)
        else $error("have_reading cleared without reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < SLOT_LIM)
        else $error("slot out of range");

    // accepted reading becomes the new reference
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && accept |=> knob_last_reg == $past(pos) && !wide_zone_reg)
        else $error("knob reference not updated on acceptance");

endmodule

### design/pedal_control_panel_unit.sv
// Pedal control panel top level: config registers, input and result registers.
//
// Usage:
//   Input stream s_tvalid/s_tready/s_tdata carries one panel sample per item:
//   toggle pins, foot switch level and knob code. Each sample yields exactly
//   one result item on m_tvalid/m_tready/m_tdata with the enable, mode, slot
//   selection and the knob acceptance flags and position.
//   The cfg_* channel writes knob_gain (0), knob_offset (1) and deadband (2);
//   other indexes are ignored. cfg_ready is always high; write only while
//   no items are in flight.
//   An accepted item passes the input register, then the result register that
//   drives m_tvalid. The knob is scaled (one multiply) as the item enters the
//   input register; state update and result formation run between the two.
//   Throughput: one item per cycle, while m_tready is high.
//   When the receiver stalls the result register holds, the input register
//   still takes one more item, then s_tready drops until the result drains.
//   Reset (aresetn low, synchronous) empties both registers, restores the
//   register defaults and returns the panel to set mode, enabled, slot 0,
//   with no knob reading taken.
`timescale 1ns / 1ps

module pedal_control_panel_unit import pcp_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int KNOB_BITS = KNOB_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // toggle_a_low, toggle_b_low, foot_level, knob_code (low bit first)
    input  logic [((3+KNOB_BITS+7)/8)*8-1:0] s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // fx_on, switch_mode, effect_slot, routed_slot, slot_changed,
    // param_changed, knob_accepted, knob_position (low bit first)
    output logic [OUT_TDATA_W-1:0] m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pcp_cfg_t    cfg_reg;
    pcp_item_t   item_reg;
    logic        in_vld_reg;
    pcp_result_t res_reg;
    logic        out_vld_reg;

    logic        advance;
    logic        s_accept;
    logic [POS_W-1:0] knob_pos;
    pcp_result_t result;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    pcp_knob_scale #(
        .KNOB_BITS (KNOB_BITS)
    ) u_scale (
        .knob_code   (s_tdata[3 +: KNOB_BITS]),
        .knob_gain   (cfg_reg.knob_gain),
        .knob_offset (cfg_reg.knob_offset),
        .knob_pos    (knob_pos)
    );

    pcp_panel_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.knob_gain   <= KNOB_GAIN_RST;
            cfg_reg.knob_offset <= KNOB_OFFSET_RST;
            cfg_reg.deadband    <= DEADBAND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (pcp_reg_t'(cfg_addr))
                REG_KNOB_GAIN:   cfg_reg.knob_gain   <= cfg_data;
                REG_KNOB_OFFSET: cfg_reg.knob_offset <= cfg_data;
                REG_DEADBAND:    cfg_reg.deadband    <= cfg_data[ZONE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.toggle_a_low <= s_tdata[0];
            item_reg.toggle_b_low <= s_tdata[1];
            item_reg.foot_level   <= s_tdata[2];
            item_reg.knob_pos     <= knob_pos;
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(pcp_result_t))'(0), res_reg};

endmodule
